@@ src/zbg_pkg.sv @@
// Shared types and constants for the zoned block-to-geometry decoder.
package zbg_pkg;

    // Shared divider: dividend and divisor widths, step counter width
    localparam int DIV_W = 17;
    localparam int DVS_W = 11;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Fixed widths taken from the register and field definitions
    localparam int SEC_W  = 13;   // sectors per track, up to 4096
    localparam int TRK_W  = 11;   // track counter, up to 2047
    localparam int SUM_W  = 27;   // scaled running block count
    localparam int SURF_W = 5;    // surface count, 1..16

    // Configuration register indexes
    localparam logic [1:0] CFG_SURFACE = 2'd0;
    localparam logic [1:0] CFG_TRACKS  = 2'd1;
    localparam logic [1:0] CFG_INNER   = 2'd2;
    localparam logic [1:0] CFG_OUTER   = 2'd3;

    // Request into the shared divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    // Response from the shared divider
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ src/zbg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module zbg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zbg_pkg::t_div_req i_req,
    output zbg_pkg::t_div_rsp o_rsp
);
    import zbg_pkg::*;

    logic [DIV_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    // One shift-and-subtract step
    assign trial = {r_rem, r_quot[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_cnt  <= CNT_W'(DIV_W);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rem  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

@@ src/zoned_block_to_geometry_decode.sv @@
// Top level: sequencer walking the zoned track layout around a shared divider.
// Steps: the divider computes the sector slope, the walk then visits the tracks in turn
// (up to the clamped track count); the divider then splits the offset in the found track.
// One request at a time; busy stays high until the result strobe.
// The result strobe is high for a single cycle; it cannot be held off.
// Reset (synchronous, active low) returns to idle and loads the register defaults.
module zoned_block_to_geometry_decode #(
    parameter int MAX_TRACKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_block_number,
    // result
    output logic        o_valid,
    output logic        o_in_range,
    output logic [3:0]  o_surface_index,
    output logic [9:0]  o_track_index,
    output logic [11:0] o_sector_index,
    output logic [16:0] o_blocks_to_track_end,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import zbg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOPE,
        S_WALK,
        S_OFFS
    } t_state;

    // Configuration registers
    logic [4:0]  r_surface_count;
    logic [10:0] r_track_count;
    logic [12:0] r_inner_sectors;
    logic [12:0] r_outer_sectors;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_count <= 5'd4;
            r_track_count   <= 11'd1024;
            r_inner_sectors <= 13'd256;
            r_outer_sectors <= 13'd512;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SURFACE: r_surface_count <= i_cfg_data[4:0];
                CFG_TRACKS:  r_track_count   <= i_cfg_data[10:0];
                CFG_INNER:   r_inner_sectors <= i_cfg_data;
                CFG_OUTER:   r_outer_sectors <= i_cfg_data;
            endcase
        end
    end

    // Clamped geometry (the user must keep the registers static while busy; not enforced here)
    logic [SURF_W-1:0] surf_c;
    logic [TRK_W-1:0]  tracks_c;
    logic [TRK_W-1:0]  tm1;
    logic [SEC_W-1:0]  inner_c;
    logic [SEC_W-1:0]  outer_c;
    logic [SEC_W-1:0]  slope_span;

    always_comb begin
        if (r_surface_count == 5'd0)       surf_c = 5'd1;
        else if (r_surface_count > 5'd16)  surf_c = 5'd16;
        else                               surf_c = r_surface_count;

        if (r_track_count < 11'd2)                          tracks_c = 11'd2;
        else if ({21'd0, r_track_count} > 32'(MAX_TRACKS))  tracks_c = TRK_W'(MAX_TRACKS);
        else                                                tracks_c = r_track_count;

        if (r_inner_sectors == 13'd0)         inner_c = 13'd1;
        else if (r_inner_sectors > 13'd4096)  inner_c = 13'd4096;
        else                                  inner_c = r_inner_sectors;

        if (r_outer_sectors < inner_c)        outer_c = inner_c;
        else if (r_outer_sectors > 13'd4096)  outer_c = 13'd4096;
        else                                  outer_c = r_outer_sectors;
    end

    assign tm1        = tracks_c - 1'b1;
    assign slope_span = outer_c - inner_c;

    // Sequencer registers
    t_state            r_state;
    logic [31:0]       r_blk;
    logic [TRK_W-1:0]  r_t;
    logic [SEC_W-1:0]  r_spt;
    logic [TRK_W-1:0]  r_frac;
    logic [11:0]       r_step_q;
    logic [TRK_W-1:0]  r_step_r;
    logic [SUM_W-1:0]  r_before_s;

    // Divider hookup
    t_div_req div_req;
    t_div_rsp div_rsp;

    zbg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Per-track step: scaled end of this track, hit test, next sector count
    logic [16:0]      spt_s;
    logic [SUM_W:0]   track_end;
    logic             hit;
    logic [TRK_W:0]   frac_sum;
    logic             carry;
    logic [16:0]      offset;

    assign spt_s     = {4'd0, r_spt} * {12'd0, surf_c};
    assign track_end = {1'b0, r_before_s} + (SUM_W+1)'(spt_s);
    assign hit       = ({4'd0, track_end} > r_blk);
    assign frac_sum  = {1'b0, r_frac} + {1'b0, r_step_r};
    assign carry     = (frac_sum >= {1'b0, tm1});
    assign offset    = 17'(r_blk - {5'd0, r_before_s});

    always_comb begin
        div_req = '0;
        if (r_state == S_IDLE && start) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(slope_span);
            div_req.divisor  = tm1;
        end else if (r_state == S_WALK && hit) begin
            div_req.start    = 1'b1;
            div_req.dividend = offset;
            div_req.divisor  = DVS_W'(surf_c);
        end
    end

    // Remaining blocks from the found sector to the end of its track
    logic [SEC_W-1:0] sec_left;
    logic [16:0]      left_s;

    assign sec_left = r_spt - {1'b0, div_rsp.quot[11:0]};
    assign left_s   = {4'd0, sec_left} * {12'd0, surf_c};

    assign busy = (r_state != S_IDLE);

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_blk   <= i_block_number;
                        r_state <= S_SLOPE;
                    end
                end
                S_SLOPE: begin
                    if (div_rsp.done) begin
                        r_step_q   <= div_rsp.quot[11:0];
                        r_step_r   <= div_rsp.rem;
                        r_t        <= '0;
                        r_spt      <= inner_c;
                        r_frac     <= '0;
                        r_before_s <= '0;
                        r_state    <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (hit) begin
                        r_state <= S_OFFS;
                    end else if (r_t == tm1) begin
                        // past capacity: report all zero
                        o_valid               <= 1'b1;
                        o_in_range            <= 1'b0;
                        o_surface_index       <= '0;
                        o_track_index         <= '0;
                        o_sector_index        <= '0;
                        o_blocks_to_track_end <= '0;
                        r_state               <= S_IDLE;
                    end else begin
                        r_t        <= r_t + 1'b1;
                        r_before_s <= track_end[SUM_W-1:0];
                        r_frac     <= carry ? TRK_W'(frac_sum - {1'b0, tm1})
                                            : frac_sum[TRK_W-1:0];
                        r_spt      <= r_spt + {1'b0, r_step_q} + {12'd0, carry};
                    end
                end
                S_OFFS: begin
                    if (div_rsp.done) begin
                        o_valid               <= 1'b1;
                        o_in_range            <= 1'b1;
                        o_surface_index       <= div_rsp.rem[3:0];
                        o_track_index         <= r_t[9:0];
                        o_sector_index        <= div_rsp.quot[11:0];
                        o_blocks_to_track_end <= left_s - {13'd0, div_rsp.rem[3:0]};
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ bench/zbg_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the zoned block-to-geometry decoder: predicts every decode and compares.
module zbg_checker #(
    parameter int MAX_TRACKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_block_number,
    // result side
    input  logic        i_valid,
    input  logic        i_in_range,
    input  logic [3:0]  i_surface_index,
    input  logic [9:0]  i_track_index,
    input  logic [11:0] i_sector_index,
    input  logic [16:0] i_blocks_to_track_end,
    // configuration writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // status towards the top
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_beyond,
    output logic [31:0] o_capacity
);

    // One decoded location
    typedef struct packed {
        logic        in_range;
        logic [3:0]  surface;
        logic [9:0]  track;
        logic [11:0] sector;
        logic [16:0] to_end;
    } t_geometry;

    // Raw register copies, as written
    logic [4:0]  surface_reg;
    logic [10:0] track_reg;
    logic [12:0] inner_reg;
    logic [12:0] outer_reg;

    // Geometry in force once the registers are clamped
    longint unsigned eff_surfaces;
    longint unsigned eff_tracks;
    longint unsigned eff_inner;
    longint unsigned eff_outer;
    longint unsigned capacity_blocks;

    t_geometry geometry_queue[$];
    t_geometry want;

    function automatic longint unsigned limit_to(input longint unsigned v,
                                                 input longint unsigned lo,
                                                 input longint unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Sectors per surface on one track of the zone ramp
    function automatic longint unsigned zone_sectors(input longint unsigned trk);
        return eff_inner + (trk * (eff_outer - eff_inner)) / (eff_tracks - 1);
    endfunction

    // Clamp the registers and total up the disk
    task automatic apply_geometry();
        longint unsigned total;
        longint unsigned trk;
        eff_surfaces = limit_to(surface_reg, 1, 16);
        eff_tracks   = limit_to(track_reg, 2, MAX_TRACKS);
        eff_inner    = limit_to(inner_reg, 1, 4096);
        eff_outer    = limit_to(outer_reg, eff_inner, 4096);
        total = 0;
        for (trk = 0; trk < eff_tracks; trk++) total += zone_sectors(trk);
        capacity_blocks = total * eff_surfaces;
        o_capacity = 32'(capacity_blocks);
    endtask

    // Walk the tracks outward until the block falls inside one
    function automatic t_geometry decode_block(input logic [31:0] blk);
        t_geometry       g;
        longint unsigned filled;
        longint unsigned spt;
        longint unsigned offset;
        longint unsigned sector;
        longint unsigned surf;
        longint unsigned trk;
        longint unsigned found;
        g = '0;
        if (blk >= capacity_blocks) return g;
        filled = 0;
        found  = 0;
        spt    = eff_inner;
        for (trk = 0; trk < eff_tracks; trk++) begin
            spt = zone_sectors(trk);
            if (blk < (filled + spt) * eff_surfaces) begin
                found = trk;
                break;
            end
            filled += spt;
        end
        offset = blk - filled * eff_surfaces;
        sector = offset / eff_surfaces;
        surf   = offset % eff_surfaces;
        g.in_range = 1'b1;
        g.surface  = 4'(surf);
        g.track    = 10'(found);
        g.sector   = 12'(sector);
        g.to_end   = 17'((spt - sector) * eff_surfaces - surf);
        return g;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            o_errors++;
        end
    endtask

    // Everything is sampled on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            surface_reg = 5'd4;
            track_reg   = 11'd1024;
            inner_reg   = 13'd256;
            outer_reg   = 13'd512;
            geometry_queue.delete();
            apply_geometry();
        end else begin
            // result strobe: compare with the oldest outstanding request
            if (i_valid) begin
                if (geometry_queue.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    o_errors++;
                end else begin
                    want = geometry_queue.pop_front();
                    check_field("in_range", want.in_range, i_in_range);
                    check_field("surface_index", want.surface, i_surface_index);
                    check_field("track_index", want.track, i_track_index);
                    check_field("sector_index", want.sector, i_sector_index);
                    check_field("blocks_to_track_end", want.to_end, i_blocks_to_track_end);
                    o_results++;
                    if (!want.in_range) o_beyond++;
                end
            end
            // accepted request
            if (i_start && !i_busy) geometry_queue.push_back(decode_block(i_block_number));
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    zbg_pkg::CFG_SURFACE: surface_reg = i_cfg_data[4:0];
                    zbg_pkg::CFG_TRACKS:  track_reg   = i_cfg_data[10:0];
                    zbg_pkg::CFG_INNER:   inner_reg   = i_cfg_data;
                    zbg_pkg::CFG_OUTER:   outer_reg   = i_cfg_data;
                    default: ;
                endcase
                apply_geometry();
            end
        end
        o_pending = geometry_queue.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the zoned block-to-geometry decoder: stimulus, timeout and verdict.
module tb_top;

    localparam int MAX_TRACKS  = 1024;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_block_number = '0;
    logic        o_valid;
    logic        o_in_range;
    logic [3:0]  o_surface_index;
    logic [9:0]  o_track_index;
    logic [11:0] o_sector_index;
    logic [16:0] o_blocks_to_track_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = zbg_pkg::CFG_SURFACE;
    logic [12:0] i_cfg_data = '0;

    int          error_count;
    int          pending_count;
    int          result_count;
    int          beyond_count;
    logic [31:0] capacity;

    int cycle_count   = 0;
    int request_count = 0;
    int phase_count   = 1;   // the reset geometry counts as the first

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    zoned_block_to_geometry_decode #(
        .MAX_TRACKS(MAX_TRACKS)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_block_number       (i_block_number),
        .o_valid              (o_valid),
        .o_in_range           (o_in_range),
        .o_surface_index      (o_surface_index),
        .o_track_index        (o_track_index),
        .o_sector_index       (o_sector_index),
        .o_blocks_to_track_end(o_blocks_to_track_end),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    zbg_checker #(
        .MAX_TRACKS(MAX_TRACKS)
    ) u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_block_number       (i_block_number),
        .i_valid              (o_valid),
        .i_in_range           (o_in_range),
        .i_surface_index      (o_surface_index),
        .i_track_index        (o_track_index),
        .i_sector_index       (o_sector_index),
        .i_blocks_to_track_end(o_blocks_to_track_end),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_errors             (error_count),
        .o_pending            (pending_count),
        .o_results            (result_count),
        .o_beyond             (beyond_count),
        .o_capacity           (capacity)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles with %0d requests outstanding",
                   CYCLE_LIMIT, pending_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly short gaps, the odd long one; none at all in steady phases
    function automatic int idle_gap(input bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 40);
        return $urandom_range(100, 1200);
    endfunction

    // Present one request and hold it until the decoder takes it
    task automatic issue_block(input logic [31:0] blk, input int gap);
        start          <= 1'b1;
        i_block_number <= blk;
        do @(posedge i_clk); while (busy);
        request_count++;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop start and wait until every result is back
    task automatic finish_phase();
        start <= 1'b0;
        while (pending_count != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic program_geometry(input logic [12:0] surf, input logic [12:0] trk,
                                    input logic [12:0] inner, input logic [12:0] outer);
        write_reg(zbg_pkg::CFG_SURFACE, surf);
        write_reg(zbg_pkg::CFG_TRACKS, trk);
        write_reg(zbg_pkg::CFG_INNER, inner);
        write_reg(zbg_pkg::CFG_OUTER, outer);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        phase_count++;
    endtask

    initial begin
        logic [12:0] surf_v;
        logic [12:0] trk_v;
        logic [12:0] inner_v;
        logic [12:0] outer_v;
        logic [31:0] blk;
        int          batch;
        int          pick;
        int          off;
        bit          steady;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset geometry: first and last blocks, track zero to one boundary, beyond capacity
        issue_block(32'd0, idle_gap(1'b0));
        issue_block(32'd1, idle_gap(1'b0));
        issue_block(32'd3, idle_gap(1'b0));
        issue_block(32'd4, idle_gap(1'b0));
        issue_block(32'd1023, idle_gap(1'b0));
        issue_block(32'd1024, idle_gap(1'b0));
        issue_block(capacity - 1, idle_gap(1'b0));
        issue_block(capacity, idle_gap(1'b0));
        issue_block(32'hFFFF_FFFF, idle_gap(1'b0));
        finish_phase();

        // Largest geometry in range
        program_geometry(13'd16, 13'd1024, 13'd4096, 13'd4096);
        issue_block(32'd0, idle_gap(1'b0));
        issue_block(capacity - 1, idle_gap(1'b0));
        issue_block(capacity, idle_gap(1'b0));
        issue_block(32'hAAAA_AAAA, idle_gap(1'b0));
        finish_phase();

        // Registers below their minimum: clamp to one surface, two tracks, one sector
        program_geometry(13'd0, 13'd1, 13'd0, 13'd0);
        issue_block(32'd0, idle_gap(1'b0));
        issue_block(32'd1, idle_gap(1'b0));
        issue_block(32'd2, idle_gap(1'b0));
        finish_phase();

        // All data bits set: masked, then clamped to the top of each range
        program_geometry(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        issue_block(capacity - 1, idle_gap(1'b0));
        issue_block(32'h5555_5555, idle_gap(1'b0));
        finish_phase();

        // Zero tracks and an outer count below the inner one
        program_geometry(13'd3, 13'd0, 13'd100, 13'd50);
        issue_block(32'd299, idle_gap(1'b0));
        issue_block(32'd300, idle_gap(1'b0));
        issue_block(capacity - 1, idle_gap(1'b0));
        issue_block(capacity, idle_gap(1'b0));

        // Random geometries, each with a batch of requests
        while (request_count < 540) begin
            finish_phase();
            surf_v  = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(1, 16))
                                                   : 13'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                trk_v = 13'($urandom_range(2, 16));
            end else if (pick < 80) begin
                trk_v = 13'($urandom_range(2, 1024));
            end else begin
                trk_v = 13'($urandom());
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                inner_v = 13'($urandom_range(1, 64));
            end else if (pick < 85) begin
                inner_v = 13'($urandom_range(1, 4096));
            end else begin
                inner_v = 13'($urandom());
            end
            if ($urandom_range(0, 99) < 70) begin
                outer_v = 13'($urandom_range((inner_v <= 13'd4096) ? inner_v : 13'd4096, 4096));
            end else begin
                outer_v = 13'($urandom());
            end
            program_geometry(surf_v, trk_v, inner_v, outer_v);

            steady = ($urandom_range(0, 3) == 0);
            batch  = $urandom_range(15, 40);
            repeat (batch) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    blk = $urandom_range(0, capacity - 1);
                end else if (pick < 70) begin
                    // straddle the capacity boundary
                    blk = capacity - 2 + $urandom_range(0, 3);
                end else if (pick < 80) begin
                    blk = $urandom_range(0, 2047);
                end else if (pick < 90) begin
                    // outermost tracks
                    off = $urandom_range(1, 4096);
                    blk = (off > capacity) ? 32'd0 : capacity - off;
                end else begin
                    blk = $urandom();
                end
                issue_block(blk, idle_gap(steady));
            end
        end
        finish_phase();
        repeat (20) @(negedge i_clk);

        $display("Decoded %0d block requests over %0d disk geometries, %0d beyond capacity.",
                 result_count, phase_count, beyond_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
